[rtl/trzc_pkg.sv]
// Shared types, event codes and zone constants of the touch release zone classifier.
package trzc_pkg;

  localparam int ValW   = 16;
  localparam int TypeW  = 5;
  localparam int CodeW  = 10;
  localparam int CfgIdxW = 8;
  localparam int NormW  = ValW + 1;
  localparam int ProdW  = NormW + 5;

  localparam logic [TypeW-1:0] EVT_KEY = TypeW'(1);
  localparam logic [TypeW-1:0] EVT_ABS = TypeW'(3);

  localparam logic [CodeW-1:0] CODE_X     = CodeW'(0);
  localparam logic [CodeW-1:0] CODE_Y     = CodeW'(1);
  localparam logic [CodeW-1:0] CODE_MT_X  = CodeW'(53);
  localparam logic [CodeW-1:0] CODE_MT_Y  = CodeW'(54);
  localparam logic [CodeW-1:0] CODE_TOUCH = CodeW'(330);

  localparam logic [ValW-1:0] KEY_RELEASE = ValW'(0);
  localparam logic [ValW-1:0] KEY_PRESS   = ValW'(1);

  localparam logic [CfgIdxW-1:0] CFG_X_MIN = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_X_MAX = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_Y_MIN = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_Y_MAX = CfgIdxW'(3);

  localparam logic [3:0] K_SCALE  = 4'd10;
  localparam logic [3:0] K_EDGE   = 4'd8;
  localparam logic [3:0] K_LEFT   = 4'd3;
  localparam logic [3:0] K_RIGHT  = 4'd7;
  localparam logic [3:0] K_MIDDLE = 4'd5;

  typedef enum logic [1:0] {
    BTN_MENU  = 2'd0,
    BTN_BACK  = 2'd1,
    BTN_PLUS  = 2'd2,
    BTN_MINUS = 2'd3
  } button_t;

  typedef struct packed {
    logic [ValW-1:0] x_min;
    logic [ValW-1:0] x_max;
    logic [ValW-1:0] y_min;
    logic [ValW-1:0] y_max;
  } range_cfg_t;

  typedef struct packed {
    logic    hit;
    button_t button;
  } zone_res_t;

  // Multiplies a signed offset by a small constant without overflow.
  function automatic logic signed [ProdW-1:0] mul_k(input logic signed [NormW-1:0] n,
                                                     input logic [3:0] k);
    logic signed [ProdW-1:0] ne;
    logic signed [ProdW-1:0] ke;
    ne = ProdW'(n);
    ke = $signed({{(ProdW-4){1'b0}}, k});
    return ne * ke;
  endfunction

endpackage

[rtl/trzc_classify.sv]
// Zone classifier: maps the last position to a button code by exact integer comparisons.
module trzc_classify (
  input  logic [trzc_pkg::ValW-1:0] last_x,
  input  logic [trzc_pkg::ValW-1:0] last_y,
  input  trzc_pkg::range_cfg_t      cfg,
  output trzc_pkg::zone_res_t       res
);
  import trzc_pkg::*;

  logic signed [NormW-1:0] nx, ny, dx, dy;
  logic signed [ProdW-1:0] nx10, ny10;
  logic                    range_ok;
  logic                    top_band, far_right, left_zone, right_zone, lower_half;

  assign nx = $signed({1'b0, last_x}) - $signed({1'b0, cfg.x_min});
  assign ny = $signed({1'b0, last_y}) - $signed({1'b0, cfg.y_min});
  assign dx = $signed({1'b0, cfg.x_max}) - $signed({1'b0, cfg.x_min});
  assign dy = $signed({1'b0, cfg.y_max}) - $signed({1'b0, cfg.y_min});

  assign nx10 = mul_k(nx, K_SCALE);
  assign ny10 = mul_k(ny, K_SCALE);

  assign range_ok   = (cfg.x_max > cfg.x_min) && (cfg.y_max > cfg.y_min);
  assign top_band   = ny10 > mul_k(dy, K_EDGE);
  assign far_right  = nx10 > mul_k(dx, K_EDGE);
  assign left_zone  = nx10 < mul_k(dx, K_LEFT);
  assign right_zone = nx10 > mul_k(dx, K_RIGHT);
  assign lower_half = ny10 < mul_k(dy, K_MIDDLE);

  always_comb begin
    res.hit    = 1'b0;
    res.button = BTN_MENU;
    if (range_ok) begin
      if (top_band) begin
        if (left_zone) begin
          res.hit    = 1'b1;
          res.button = BTN_MENU;
        end else if (right_zone) begin
          res.hit    = 1'b1;
          res.button = BTN_BACK;
        end
      end else if (far_right) begin
        res.hit    = 1'b1;
        res.button = lower_half ? BTN_PLUS : BTN_MINUS;
      end
    end
  end

endmodule

[rtl/touch_release_zone_classifier.sv]
// Top level: event register, position and touch tracking, and registered button output.
// An event enters the event register; its button word is then registered at the output.
// Throughput: one event word per cycle; the event register advances whenever the output
// register is empty or being taken.
// Reset (synchronous, rst_n low) clears the range registers, last position, touch flag
// and both valid flags.
module touch_release_zone_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [trzc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [trzc_pkg::ValW-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trzc_pkg::TypeW-1:0]    in_event_type,
  input  logic [trzc_pkg::CodeW-1:0]    in_event_code,
  input  logic [trzc_pkg::ValW-1:0]     in_event_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_button
);
  import trzc_pkg::*;

  range_cfg_t       cfg_r;
  logic             ev_valid_r;
  logic [TypeW-1:0] ev_type_r;
  logic [CodeW-1:0] ev_code_r;
  logic [ValW-1:0]  ev_value_r;
  logic [ValW-1:0]  last_x_r, last_x_nxt;
  logic [ValW-1:0]  last_y_r, last_y_nxt;
  logic             touch_down_r, touch_down_nxt;
  logic             out_valid_r, out_valid_nxt;
  button_t          out_button_r, out_button_nxt;
  logic             ev_adv, is_abs, is_touch, emit;
  zone_res_t        zone;

  trzc_classify u_classify (
    .last_x (last_x_r),
    .last_y (last_y_r),
    .cfg    (cfg_r),
    .res    (zone)
  );

  assign ev_adv   = ev_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ev_valid_r || ev_adv;
  assign is_abs   = ev_type_r == EVT_ABS;
  assign is_touch = (ev_type_r == EVT_KEY) && (ev_code_r == CODE_TOUCH);
  assign emit     = is_touch && (ev_value_r == KEY_RELEASE) && touch_down_r && zone.hit;

  always_comb begin
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    touch_down_nxt = touch_down_r;
    if (ev_adv) begin
      if (is_abs && ((ev_code_r == CODE_X) || (ev_code_r == CODE_MT_X))) begin
        last_x_nxt = ev_value_r;
      end
      if (is_abs && ((ev_code_r == CODE_Y) || (ev_code_r == CODE_MT_Y))) begin
        last_y_nxt = ev_value_r;
      end
      if (is_touch && (ev_value_r == KEY_PRESS)) begin
        touch_down_nxt = 1'b1;
      end else if (is_touch && (ev_value_r == KEY_RELEASE)) begin
        touch_down_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_button_nxt = out_button_r;
    if (ev_adv) begin
      out_valid_nxt  = emit;
      out_button_nxt = zone.button;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= '0;
      ev_valid_r   <= 1'b0;
      last_x_r     <= '0;
      last_y_r     <= '0;
      touch_down_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_X_MIN: cfg_r.x_min <= cfg_wdata;
          CFG_X_MAX: cfg_r.x_max <= cfg_wdata;
          CFG_Y_MIN: cfg_r.y_min <= cfg_wdata;
          CFG_Y_MAX: cfg_r.y_max <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ready) begin
        ev_valid_r <= in_valid;
      end
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      touch_down_r <= touch_down_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ev_type_r  <= in_event_type;
      ev_code_r  <= in_event_code;
      ev_value_r <= in_event_value;
    end
    out_button_r <= out_button_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_button = out_button_r;

`ifndef SYNTHESIS
  a_emit_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_adv && emit) |-> touch_down_r)
    else $error("button emitted without a preceding press");

  a_emit_clears_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_adv && emit) |=> !touch_down_r)
    else $error("touch flag not cleared after a release");

  a_emit_needs_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_adv && emit) |-> ((cfg_r.x_max > cfg_r.x_min) && (cfg_r.y_max > cfg_r.y_min)))
    else $error("button emitted with an empty range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_valid_r && !ev_adv) |-> !in_ready)
    else $error("event register would be overwritten");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ev_adv)
    else $error("pending button word would be overwritten");
`endif

endmodule
